[rtl/lss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// shared types and codes of the lifo stack with search
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_PEEK    = 3'd2,
    MODE_DISPLAY = 3'd3,
    MODE_SEARCH  = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FLUSH
  } state_t;

  typedef enum logic [3:0] {
    EM_NONE,
    EM_FULL,
    EM_PUSH,
    EM_EMPTY,
    EM_TOP,
    EM_CLEAR,
    EM_DISP,
    EM_MATCH_MID,
    EM_MATCH_LAST,
    EM_NOTFOUND
  } emit_t;

  typedef struct packed {
    logic        load;
    emit_t       emit;
    logic        push_wr;
    logic        pop;
    logic        clr;
    logic        step;
    logic        set_pend;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        empty;
    logic        full;
    logic        at_end;
    logic        match;
    logic        hit;
    logic        out_free;
  } dp_stat_t;

endpackage

[rtl/lss_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/lss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl
// operation sequencer: dispatch, entry walk and search flush
// ----------------------------------------------------------------------------
module lss_ctrl
  import lss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   srch_ok;

  // a second match can only advance once the pending one is sent
  assign srch_ok   = !(stat.match && stat.hit) || stat.out_free;
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (stat.mode)
          MODE_PUSH, MODE_POP, MODE_PEEK, MODE_CLEAR: begin
            if (stat.out_free) state_nxt = S_IDLE;
          end
          MODE_DISPLAY, MODE_SEARCH: begin
            if (!stat.empty) state_nxt = S_WALK;
            else if (stat.out_free) state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WALK: begin
        if (stat.mode == MODE_DISPLAY) begin
          if (stat.out_free && stat.at_end) state_nxt = S_IDLE;
        end else begin
          if (srch_ok && stat.at_end) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.emit     = EM_NONE;
    cmd.load     = (state_r == S_IDLE) && in_tvalid;
    unique case (state_r)
      S_IDLE: ;
      S_EXEC: begin
        if (stat.out_free) begin
          case (stat.mode)
            MODE_PUSH: begin
              cmd.emit    = stat.full ? EM_FULL : EM_PUSH;
              cmd.push_wr = !stat.full;
            end
            MODE_POP: begin
              cmd.emit = stat.empty ? EM_EMPTY : EM_TOP;
              cmd.pop  = !stat.empty;
            end
            MODE_PEEK: begin
              cmd.emit = stat.empty ? EM_EMPTY : EM_TOP;
            end
            MODE_DISPLAY, MODE_SEARCH: begin
              if (stat.empty) cmd.emit = EM_EMPTY;
            end
            MODE_CLEAR: begin
              cmd.emit = EM_CLEAR;
              cmd.clr  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (stat.mode == MODE_DISPLAY) begin
          if (stat.out_free) begin
            cmd.emit = EM_DISP;
            cmd.step = !stat.at_end;
          end
        end else if (srch_ok) begin
          if (stat.match) begin
            cmd.set_pend = 1'b1;
            if (stat.hit) cmd.emit = EM_MATCH_MID;
          end
          cmd.step = !stat.at_end;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit = stat.hit ? EM_MATCH_LAST : EM_NOTFOUND;
        end
      end
    endcase
  end

endmodule

[rtl/lss_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_dp
// stack store, entry count, walk pointer and result register
// ----------------------------------------------------------------------------
module lss_dp
  import lss_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_mode,
  input  logic [WORD_W-1:0] in_value,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [1:0]        out_status,
  output logic [WORD_W-1:0] out_word,
  output logic [POS_W-1:0]  out_position,
  output logic              out_last
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic [CW-1:0]            pend_r, pend_nxt;
  logic                     hit_r, hit_nxt;
  logic [2:0]               mode_r, mode_nxt;
  logic signed [WORD_W-1:0] value_r, value_nxt;
  logic [WORD_W-1:0]        ram_q;

  logic                     ovld_r, ovld_nxt;
  status_t                  ost_r, ost_nxt;
  logic signed [WORD_W-1:0] oword_r, oword_nxt;
  logic [POS_W-1:0]         opos_r, opos_nxt;
  logic                     olast_r, olast_nxt;

  assign cnt_m1 = count_r - CW'(1);

  lss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.push_wr),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (value_r),
    .rd_addr (idx_nxt),
    .rd_data (ram_q)
  );

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    hit_nxt   = hit_r;
    mode_nxt  = mode_r;
    value_nxt = value_r;
    if (cmd.load) begin
      mode_nxt  = in_mode;
      value_nxt = in_value;
      idx_nxt   = cnt_m1[AW-1:0];
      pos_nxt   = CW'(1);
      hit_nxt   = 1'b0;
    end
    if (cmd.step) begin
      idx_nxt = idx_r - AW'(1);
      pos_nxt = pos_r + CW'(1);
    end
    if (cmd.set_pend) begin
      pend_nxt = pos_r;
      hit_nxt  = 1'b1;
    end
    if (cmd.push_wr) count_nxt = count_r + CW'(1);
    if (cmd.pop)     count_nxt = cnt_m1;
    if (cmd.clr)     count_nxt = '0;
  end

  always_comb begin
    ovld_nxt  = out_tready ? 1'b0 : ovld_r;
    ost_nxt   = ost_r;
    oword_nxt = oword_r;
    opos_nxt  = opos_r;
    olast_nxt = olast_r;
    if (cmd.emit != EM_NONE) begin
      ovld_nxt  = 1'b1;
      ost_nxt   = ST_OK;
      oword_nxt = '0;
      opos_nxt  = '0;
      olast_nxt = 1'b1;
    end
    unique case (cmd.emit)
      EM_NONE, EM_CLEAR: ;
      EM_FULL:     ost_nxt = ST_FULL;
      EM_EMPTY:    ost_nxt = ST_EMPTY;
      EM_NOTFOUND: ost_nxt = ST_NOTFOUND;
      EM_PUSH: begin
        oword_nxt = value_r;
        opos_nxt  = POS_W'(1);
      end
      EM_TOP: begin
        oword_nxt = ram_q;
        opos_nxt  = POS_W'(1);
      end
      EM_DISP: begin
        oword_nxt = ram_q;
        opos_nxt  = POS_W'(pos_r);
        olast_nxt = (idx_r == '0);
      end
      EM_MATCH_MID: begin
        oword_nxt = value_r;
        opos_nxt  = POS_W'(pend_r);
        olast_nxt = 1'b0;
      end
      EM_MATCH_LAST: begin
        oword_nxt = value_r;
        opos_nxt  = POS_W'(pend_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hit_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      hit_r   <= hit_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    pend_r  <= pend_nxt;
    mode_r  <= mode_nxt;
    value_r <= value_nxt;
    ost_r   <= ost_nxt;
    oword_r <= oword_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
  end

  assign stat.mode     = mode_r;
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CW'(STACK_DEPTH));
  assign stat.at_end   = (idx_r == '0);
  assign stat.match    = (ram_q == value_r);
  assign stat.hit      = hit_r;
  assign stat.out_free = !ovld_r || out_tready;

  assign out_tvalid   = ovld_r;
  assign out_status   = ost_r;
  assign out_word     = oword_r;
  assign out_position = opos_r;
  assign out_last     = olast_r;

endmodule

[rtl/lifo_stack_with_search_core.sv]
`timescale 1ns / 1ps
// push, pop, peek and clear: executed in the exec state, result registered at the output
// display of n entries: one result per cycle in the walk state, while the output is free
// search: each match waits for the next; the last match or not found is sent from flush
// a new transaction is taken once the previous one has issued its last result
// reset: synchronous active-low, empties the stack and drops any held result
// ----------------------------------------------------------------------------
// lifo_stack_with_search_core
// bounded lifo stack of signed words with display and key search
// ----------------------------------------------------------------------------
module lifo_stack_with_search_core
  import lss_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // word[31:0], position[36:32], zero[39:37]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [WORD_W-1:0] word;
  logic [POS_W-1:0]  position;

  lss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lss_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mode      (in_tuser),
    .in_value     (in_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_status   (out_tuser),
    .out_word     (word),
    .out_position (position),
    .out_last     (out_tlast)
  );

  assign out_tdata = {3'b000, position, word};

endmodule
